### sv/irt_pkg.sv
// shared constants, types and the digit-to-character function for the radix text block
`default_nettype none

package irt_pkg;

    // value width and digit cell row
    localparam int VALUE_WIDTH = 32;
    localparam int NUM_CELLS   = VALUE_WIDTH;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W      = $clog2(NUM_CELLS + 1);

    // base limits
    localparam logic [DIGIT_W-1:0] MIN_RADIX      = DIGIT_W'(2);
    localparam logic [DIGIT_W-1:0] MAX_RADIX      = DIGIT_W'(36);
    localparam logic [DIGIT_W-1:0] FALLBACK_RADIX = DIGIT_W'(10);
    localparam logic [DIGIT_W-1:0] NUM_DECIMAL    = DIGIT_W'(10);

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CH_NINE    = CHAR_W'(8'h39);
    localparam logic [CHAR_W-1:0] CH_UPPER_A = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = CHAR_W'(8'h5A);
    localparam logic [CHAR_W-1:0] CH_LOWER_A = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = CHAR_W'(8'h7A);
    localparam logic [CHAR_W-1:0] CH_MINUS   = CHAR_W'(8'h2D);

    typedef logic [DIGIT_W-1:0] t_digit;

    // per-cycle command to every digit cell
    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctl;

    // digit value to ascii, letters in the chosen case
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input t_digit d, input logic upper);
        logic [CHAR_W-1:0] base_char;
        if (d < NUM_DECIMAL) begin
            digit_to_ascii = CH_ZERO + CHAR_W'(d);
        end else begin
            base_char = upper ? CH_UPPER_A : CH_LOWER_A;
            digit_to_ascii = base_char + CHAR_W'(d - NUM_DECIMAL);
        end
    endfunction

endpackage

`default_nettype wire

### sv/integer_to_radix_text.sv
// The '-' of a negative number enters the output register once its word is taken and the register is free;
// the digits follow once the VALUE_WIDTH input bits have been fed in serially and have passed the
// skew of VALUE_WIDTH-1 cells, and the leading zeros have been dropped; one cell is shifted out per
// output character. A new number is taken only after the last character of the previous one is loaded.
// Reset (synchronous, active low) clears the sequencer, output valid and cell tokens;
// the digit cells are cleared when each word is taken.
`default_nettype none

module integer_to_radix_text (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [irt_pkg::VALUE_WIDTH-1:0] i_number,
    input  logic [irt_pkg::DIGIT_W-1:0]         i_radix,
    input  logic                                i_upper_letters,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [irt_pkg::CHAR_W-1:0]          o_char_code,
    output logic                                o_last_char
);
    import irt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;
    t_digit                 r_radix;
    t_digit                 n_radix;
    logic                   r_upper;
    logic                   n_upper;
    logic                   r_sign_pend;
    logic                   n_sign_pend;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [LEFT_W-1:0]      r_left;
    logic [LEFT_W-1:0]      n_left;
    logic                   r_ovalid;
    logic                   n_ovalid;
    logic [CHAR_W-1:0]      r_char;
    logic [CHAR_W-1:0]      n_char;
    logic                   r_last;
    logic                   n_last;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_feed;
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_abs;
    t_digit                 w_radix_fix;
    t_cell_ctl              w_ctl;
    t_digit                 w_top_digit;
    logic                   w_top_act;
    logic                   w_top_carry;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_feed     = (r_state == S_CONV) && (r_cnt != CNT_W'(VALUE_WIDTH));

    // magnitude and base clean-up of the incoming word
    always_comb begin
        w_neg = i_number[VALUE_WIDTH-1];
        w_abs = w_neg ? (~i_number + 1'b1) : i_number;
        if ((i_radix < MIN_RADIX) || (i_radix > MAX_RADIX)) begin
            w_radix_fix = FALLBACK_RADIX;
        end else begin
            w_radix_fix = i_radix;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_radix     = r_radix;
        n_upper     = r_upper;
        n_sign_pend = r_sign_pend;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_ovalid    = r_ovalid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mag       = w_abs;
                    n_radix     = w_radix_fix;
                    n_upper     = i_upper_letters;
                    n_sign_pend = w_neg;
                    n_cnt       = '0;
                    w_ctl.clear = 1'b1;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.conv = 1'b1;
                if (w_feed) begin
                    n_mag = r_mag << 1;
                    n_cnt = r_cnt + 1'b1;
                end else if (!w_top_act && !w_top_carry) begin
                    n_left  = LEFT_W'(NUM_CELLS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits, keep at least one
                if ((w_top_digit == '0) && (r_left != LEFT_W'(1))) begin
                    w_ctl.shift = 1'b1;
                    n_left      = r_left - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && !r_sign_pend) begin
                    n_ovalid    = 1'b1;
                    n_char      = digit_to_ascii(w_top_digit, r_upper);
                    n_last      = (r_left == LEFT_W'(1));
                    w_ctl.shift = 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // minus sign goes out as soon as the output register is free
        if ((r_state != S_IDLE) && r_sign_pend && w_out_free) begin
            n_ovalid    = 1'b1;
            n_char      = CH_MINUS;
            n_last      = 1'b0;
            n_sign_pend = 1'b0;
        end
    end

    irt_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_radix     (r_radix),
        .i_bit       (r_mag[VALUE_WIDTH-1]),
        .i_feed      (w_feed),
        .o_top_digit (w_top_digit),
        .o_top_act   (w_top_act),
        .o_top_carry (w_top_carry)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_sign_pend <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_ovalid    <= n_ovalid;
            r_sign_pend <= n_sign_pend;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_radix <= n_radix;
        r_upper <= n_upper;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

### sv/irt_cell.sv
// one digit cell: doubles its digit and adds the carry from below, modulo the base
`default_nettype none

module irt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  irt_pkg::t_cell_ctl i_ctl,
    input  irt_pkg::t_digit   i_radix,
    input  irt_pkg::t_digit   i_digit,
    input  logic              i_carry,
    input  logic              i_act,
    output irt_pkg::t_digit   o_digit,
    output logic              o_carry,
    output logic              o_act
);
    import irt_pkg::*;

    t_digit             r_digit;
    t_digit             n_digit;
    logic               r_carry;
    logic               n_carry;
    logic               r_act;
    logic               n_act;
    logic [DIGIT_W:0]   w_sum;
    logic               w_ge;

    // twice the digit plus incoming carry, compared with the base
    always_comb begin
        w_sum = {r_digit, i_carry};
        w_ge  = w_sum >= {1'b0, i_radix};
    end

    // next digit, carry and activity token
    always_comb begin
        n_digit = r_digit;
        n_carry = 1'b0;
        n_act   = 1'b0;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_act = i_act;
            if (i_act) begin
                if (w_ge) begin
                    n_digit = DIGIT_W'(w_sum - {1'b0, i_radix});
                    n_carry = 1'b1;
                end else begin
                    n_digit = DIGIT_W'(w_sum);
                end
            end
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= 1'b0;
            r_act   <= 1'b0;
        end else begin
            r_carry <= n_carry;
            r_act   <= n_act;
        end
    end

    // digit register
    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;
    assign o_carry = r_carry;
    assign o_act   = r_act;

endmodule

`default_nettype wire

### sv/irt_chain.sv
// row of digit cells: skewed bit-serial conversion, then shift towards the top cell
`default_nettype none

module irt_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  irt_pkg::t_cell_ctl i_ctl,
    input  irt_pkg::t_digit    i_radix,
    input  logic               i_bit,
    input  logic               i_feed,
    output irt_pkg::t_digit    o_top_digit,
    output logic               o_top_act,
    output logic               o_top_carry
);
    import irt_pkg::*;

    t_digit w_digit     [NUM_CELLS];
    logic   w_carry     [NUM_CELLS];
    logic   w_act       [NUM_CELLS];
    t_digit w_digit_in  [NUM_CELLS];
    logic   w_carry_in  [NUM_CELLS];
    logic   w_act_in    [NUM_CELLS];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        // lowest cell takes the serial bit stream, others their lower neighbour
        if (k == 0) begin : g_first
            assign w_digit_in[k] = '0;
            assign w_carry_in[k] = i_bit;
            assign w_act_in[k]   = i_feed;
        end else begin : g_next
            assign w_digit_in[k] = w_digit[k-1];
            assign w_carry_in[k] = w_carry[k-1];
            assign w_act_in[k]   = w_act[k-1];
        end

        irt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_radix (i_radix),
            .i_digit (w_digit_in[k]),
            .i_carry (w_carry_in[k]),
            .i_act   (w_act_in[k]),
            .o_digit (w_digit[k]),
            .o_carry (w_carry[k]),
            .o_act   (w_act[k])
        );
    end

    assign o_top_digit = w_digit[NUM_CELLS-1];
    assign o_top_act   = w_act[NUM_CELLS-1];
    assign o_top_carry = w_carry[NUM_CELLS-1];

endmodule

`default_nettype wire

### sv/irt_checker.sv
// port-level checks for the radix text block, bound to the top level
`default_nettype none

module irt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic signed [irt_pkg::VALUE_WIDTH-1:0] i_number,
    input logic [irt_pkg::DIGIT_W-1:0]            i_radix,
    input logic                                   i_upper_letters,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic [irt_pkg::CHAR_W-1:0]             o_char_code,
    input logic                                   o_last_char
);
    import irt_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_code) && $stable(o_last_char))
        else $error("output word changed while stalled");

    // one number at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again straight after a word");

    // no new number while an unfinished text waits at the output
    a_idle_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char |-> !o_ready)
        else $error("ready while text incomplete");

    // the sign never ends a text
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CH_MINUS) |-> !o_last_char)
        else $error("minus sign marked last");

    // only sign, digits and letters appear
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CH_MINUS)
            || ((o_char_code >= CH_ZERO) && (o_char_code <= CH_NINE))
            || ((o_char_code >= CH_UPPER_A) && (o_char_code <= CH_UPPER_Z))
            || ((o_char_code >= CH_LOWER_A) && (o_char_code <= CH_LOWER_Z)))
        else $error("character outside the text set");

endmodule

bind integer_to_radix_text irt_checker u_irt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_number        (i_number),
    .i_radix         (i_radix),
    .i_upper_letters (i_upper_letters),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_char_code     (o_char_code),
    .o_last_char     (o_last_char)
);

`default_nettype wire

### tb/irt_text_checker.sv
// channel monitor, character predictor and scoreboard for the radix text block
`timescale 1ns / 100ps

module irt_text_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   o_ready,
    input  logic signed [irt_pkg::VALUE_WIDTH-1:0] i_number,
    input  logic [irt_pkg::DIGIT_W-1:0]            i_radix,
    input  logic                                   i_upper_letters,
    input  logic                                   o_valid,
    input  logic                                   i_ready,
    input  logic [irt_pkg::CHAR_W-1:0]             o_char_code,
    input  logic                                   o_last_char,
    output int                                     o_fail_count,
    output int                                     o_chars_pending,
    output int                                     o_words_taken,
    output int                                     o_chars_seen
);
    import irt_pkg::*;

    // one expected character of the text
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    t_text_char text_due[$];

    int fail_count    = 0;
    int words_taken   = 0;
    int chars_seen    = 0;
    int chars_pending = 0;

    assign o_fail_count    = fail_count;
    assign o_chars_pending = chars_pending;
    assign o_words_taken   = words_taken;
    assign o_chars_seen    = chars_seen;

    // character for one digit value
    function automatic logic [CHAR_W-1:0] glyph_of(input int unsigned d, input logic upper);
        int unsigned code;
        if (d <= 9) begin
            code = int'(CH_ZERO) + d;
        end else if (upper) begin
            code = int'(CH_UPPER_A) + (d - 10);
        end else begin
            code = int'(CH_LOWER_A) + (d - 10);
        end
        return CHAR_W'(code);
    endfunction

    // queue the full text of one number, sign first, most significant digit next
    function automatic void spell_number(input logic [VALUE_WIDTH-1:0] raw,
                                         input logic [DIGIT_W-1:0] rad,
                                         input logic upper);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] base;
        int unsigned            digit_vals[$];
        t_text_char             entry;
        int                     i;
        if (rad < MIN_RADIX || rad > MAX_RADIX) begin
            base = VALUE_WIDTH'(FALLBACK_RADIX);
        end else begin
            base = VALUE_WIDTH'(rad);
        end
        // unsigned negate keeps the most negative value at its true magnitude
        mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
        if (mag == '0) begin
            digit_vals.push_back(0);
        end
        while (mag != '0) begin
            digit_vals.push_back(int'(mag % base));
            mag = mag / base;
        end
        if (raw[VALUE_WIDTH-1]) begin
            entry.code = CH_MINUS;
            entry.last = 1'b0;
            text_due.push_back(entry);
        end
        for (i = digit_vals.size() - 1; i >= 0; i--) begin
            entry.code = glyph_of(digit_vals[i], upper);
            entry.last = (i == 0);
            text_due.push_back(entry);
        end
    endfunction

    // compare each accepted character with the oldest prediction, then predict new words
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && i_ready) begin
            chars_seen <= chars_seen + 1;
            if (text_due.size() == 0) begin
                $error("unexpected character 0x%02h last_char %0b with nothing due",
                       o_char_code, o_last_char);
                fail_count <= fail_count + 1;
            end else begin
                want = text_due.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code mismatch: expected 0x%02h, got 0x%02h",
                           want.code, o_char_code);
                    fail_count <= fail_count + 1;
                end else if (o_last_char !== want.last) begin
                    $error("last_char mismatch: expected %0b, got %0b",
                           want.last, o_last_char);
                    fail_count <= fail_count + 1;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            words_taken <= words_taken + 1;
            spell_number(i_number, i_radix, i_upper_letters);
        end
        chars_pending <= text_due.size();
    end

endmodule

### tb/tb.sv
// top of the radix text testbench: clock, reset, word stimulus, output stalls and verdict
`timescale 1ns / 100ps

module tb;
    import irt_pkg::*;

    localparam int RANDOM_WORDS = 250;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 3 * VALUE_WIDTH + 8;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [VALUE_WIDTH-1:0] i_number;
    logic [DIGIT_W-1:0]            i_radix;
    logic                          i_upper_letters;
    logic                          o_valid;
    logic                          i_ready = 1'b1;
    logic [CHAR_W-1:0]             o_char_code;
    logic                          o_last_char;

    int fail_count;
    int chars_pending;
    int words_taken;
    int chars_seen;

    int       burst_left = 0;
    int       idle_cycles = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_mode_left = 40;
    int       rx_phase = 0;

    integer_to_radix_text dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_number       (i_number),
        .i_radix        (i_radix),
        .i_upper_letters(i_upper_letters),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_code    (o_char_code),
        .o_last_char    (o_last_char)
    );

    irt_text_checker u_text_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_number       (i_number),
        .i_radix        (i_radix),
        .i_upper_letters(i_upper_letters),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_code    (o_char_code),
        .o_last_char    (o_last_char),
        .o_fail_count   (fail_count),
        .o_chars_pending(chars_pending),
        .o_words_taken  (words_taken),
        .o_chars_seen   (chars_seen)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // receiver stalls, switching pattern every so often
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(32, 256);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   i_ready <= 1'b1;
            RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   i_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_ready <= rx_phase[2];
            default:     i_ready <= 1'b1;
        endcase
    end

    // watchdog on stretches with no word accepted on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: %0d idle cycles, %0d characters still due",
                         idle_cycles, chars_pending);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // offer one word and hold it until taken, then maybe pause the burst
    task automatic send_word(input logic [VALUE_WIDTH-1:0] num, input logic [DIGIT_W-1:0] rad,
                             input logic up);
        int gap;
        i_valid         <= 1'b1;
        i_number        <= num;
        i_radix         <= rad;
        i_upper_letters <= up;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    // mix of full-range values, small values, extremes and narrow magnitudes
    function automatic logic [VALUE_WIDTH-1:0] pick_number();
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = VALUE_WIDTH'(int'($urandom_range(0, 80)) - 40);
            6: begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    1:       v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    2:       v = '1;
                    3:       v = '0;
                    default: v = VALUE_WIDTH'(1);
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
                if ($urandom_range(0, 1)) v = ~v + 1'b1;
            end
        endcase
        return v;
    endfunction

    initial begin
        int n;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_number        <= '0;
        i_radix         <= '0;
        i_upper_letters <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, extremes, fallback bases 0, 1, 37 and 63, both letter cases
        send_word(32'd0, 6'd10, 1'b0);
        send_word(32'h8000_0000, 6'd2, 1'b0);
        send_word(32'h7fff_ffff, 6'd2, 1'b1);
        send_word(32'hffff_ffff, 6'd2, 1'b0);
        send_word(32'd0, 6'd2, 1'b1);
        send_word(32'd1, 6'd2, 1'b0);
        send_word(32'hffff_ffff, 6'd36, 1'b1);
        send_word(32'h7fff_ffff, 6'd36, 1'b1);
        send_word(32'h7fff_ffff, 6'd36, 1'b0);
        send_word(32'h8000_0000, 6'd36, 1'b0);
        send_word(32'h8000_0000, 6'd10, 1'b1);
        send_word(32'd35, 6'd36, 1'b0);
        send_word(32'd35, 6'd36, 1'b1);
        send_word(32'd10, 6'd11, 1'b0);
        send_word(32'hdead_beef, 6'd16, 1'b1);
        send_word(32'hdead_beef, 6'd16, 1'b0);
        send_word(32'd12345, 6'd0, 1'b0);
        send_word(-32'sd12345, 6'd1, 1'b1);
        send_word(32'd98765, 6'd37, 1'b1);
        send_word(32'h8000_0000, 6'd63, 1'b0);
        send_word(32'd12345, 6'd8, 1'b0);
        send_word(32'h1234_5678, 6'd3, 1'b1);
        send_word(32'hffff_fffe, 6'd35, 1'b1);

        // random words, mostly in-range bases
        for (n = 0; n < RANDOM_WORDS; n++) begin
            send_word(pick_number(),
                      ($urandom_range(0, 4) == 0) ? DIGIT_W'($urandom_range(0, 63))
                                                  : DIGIT_W'($urandom_range(2, 36)),
                      1'($urandom_range(0, 1)));
        end
        i_valid <= 1'b0;

        // drain: every predicted character back, then a quiet spell
        @(posedge i_clk);
        while (chars_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d numbers and %0d characters across bases 0..63 in both cases",
                 words_taken, chars_seen);
        $display("mismatches %0d, characters still due %0d", fail_count, chars_pending);
        if (fail_count == 0 && chars_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
